// ===== rtl/core/itr_pkg.sv =====
// itr_pkg: shared widths, numeral tables and control structs for the
// integer to Roman numeral unit. No dependencies.

package itr_pkg;

    localparam int NUM_W     = 12;
    localparam int SYM_W     = 8;
    localparam int STEP_W    = 4;
    localparam int STEPS     = 13;
    localparam int MAX_VALUE = 3999;

    localparam logic [SYM_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYM_W-1:0] CH_I    = 8'h49;
    localparam logic [SYM_W-1:0] CH_V    = 8'h56;
    localparam logic [SYM_W-1:0] CH_X    = 8'h58;
    localparam logic [SYM_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYM_W-1:0] CH_C    = 8'h43;
    localparam logic [SYM_W-1:0] CH_D    = 8'h44;
    localparam logic [SYM_W-1:0] CH_M    = 8'h4D;

    typedef struct packed {
        logic load;
        logic step;
    } itr_cmd_t;

    typedef struct packed {
        logic last;
    } itr_stat_t;

    function automatic logic [NUM_W-1:0] step_value(input logic [STEP_W-1:0] idx);
        logic [NUM_W-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [SYM_W-1:0] glyph_lead(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] g;
        unique case (idx)
            4'd0:    g = CH_M;
            4'd1:    g = CH_C;
            4'd2:    g = CH_D;
            4'd3:    g = CH_C;
            4'd4:    g = CH_C;
            4'd5:    g = CH_X;
            4'd6:    g = CH_L;
            4'd7:    g = CH_X;
            4'd8:    g = CH_X;
            4'd9:    g = CH_I;
            4'd10:   g = CH_V;
            4'd11:   g = CH_I;
            default: g = CH_I;
        endcase
        return g;
    endfunction

    function automatic logic [SYM_W-1:0] glyph_tail(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] g;
        unique case (idx)
            4'd1:    g = CH_M;
            4'd3:    g = CH_D;
            4'd5:    g = CH_C;
            4'd7:    g = CH_L;
            4'd9:    g = CH_X;
            4'd11:   g = CH_V;
            default: g = CH_NONE;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/itr_ctrl.sv =====
// itr_ctrl: request sequencer for the Roman numeral unit.
// Depends on itr_pkg; drives itr_dp through itr_cmd_t / itr_stat_t.

module itr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output itr_pkg::itr_cmd_t cmd,
    input  itr_pkg::itr_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/itr_dp.sv =====
// itr_dp: remainder, greedy step select and output character register.
// Depends on itr_pkg; commanded by itr_ctrl.

module itr_dp
(
    input  logic                       clk,
    input  itr_pkg::itr_cmd_t          cmd,
    output itr_pkg::itr_stat_t         stat,
    input  logic [itr_pkg::NUM_W-1:0]  number,
    output logic [itr_pkg::SYM_W-1:0]  symbol,
    output logic                       last,
    output logic                       error
);

    logic [itr_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic                       half_reg, half_next;
    logic                       err_reg, err_next;
    logic [itr_pkg::SYM_W-1:0]  symbol_reg;
    logic                       last_reg;
    logic                       error_reg;

    logic [itr_pkg::STEP_W-1:0] sel;
    logic [itr_pkg::NUM_W-1:0]  sel_value;
    logic [itr_pkg::SYM_W-1:0]  tail;
    logic                       two;
    logic [itr_pkg::SYM_W-1:0]  cur_sym;
    logic                       cur_last;

    // largest value not above the remainder
    always_comb
    begin
        sel = itr_pkg::STEP_W'(itr_pkg::STEPS - 1);
        for (int i = itr_pkg::STEPS - 1; i >= 0; i--)
        begin
            if (rem_reg >= itr_pkg::step_value(itr_pkg::STEP_W'(i)))
            begin
                sel = itr_pkg::STEP_W'(i);
            end
        end
    end

    assign sel_value = itr_pkg::step_value(sel);
    assign tail      = itr_pkg::glyph_tail(sel);
    assign two       = (tail != itr_pkg::CH_NONE);

    always_comb
    begin
        if (err_reg)
        begin
            cur_sym  = itr_pkg::CH_NONE;
            cur_last = 1'b1;
        end
        else
        begin
            cur_sym  = half_reg ? tail : itr_pkg::glyph_lead(sel);
            cur_last = (!two || half_reg) && (rem_reg == sel_value);
        end
    end

    assign stat.last = cur_last;

    always_comb
    begin
        rem_next  = rem_reg;
        half_next = half_reg;
        err_next  = err_reg;
        priority if (cmd.load)
        begin
            rem_next  = number;
            half_next = 1'b0;
            err_next  = (number == '0) ||
                        (number > itr_pkg::NUM_W'(itr_pkg::MAX_VALUE));
        end
        else if (cmd.step && !err_reg)
        begin
            if (two && !half_reg)
            begin
                half_next = 1'b1;
            end
            else
            begin
                rem_next  = rem_reg - sel_value;
                half_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        half_reg <= half_next;
        err_reg  <= err_next;
        if (cmd.step)
        begin
            symbol_reg <= cur_sym;
            last_reg   <= cur_last;
            error_reg  <= err_reg;
        end
    end

    assign symbol = symbol_reg;
    assign last   = last_reg;
    assign error  = error_reg;

endmodule

// ===== rtl/core/integer_to_roman_numeral_unit.sv =====
// integer_to_roman_numeral_unit: top level, number in, Roman numeral letters out.
// Depends on itr_pkg, itr_ctrl and itr_dp.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata[11:0] number
//   m_       out  m_tvalid/m_tready   m_tdata symbol, m_tlast last, m_tuser error
//
// A number is loaded, then one letter per cycle while m_tready does not stall;
// the longest request is 3888, and an error gives a single letter. The datapath
// emits a letter on every step; a subtractive pair takes two steps and one subtract.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// A stalled m_tready holds the current letter; a new request is taken only once
// the previous number's last letter sits in the output register.

module integer_to_roman_numeral_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] number, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] symbol
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] error
);

    itr_pkg::itr_cmd_t  cmd;
    itr_pkg::itr_stat_t stat;
    logic               error;

    itr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    itr_dp u_dp
    (
        .clk    (clk),
        .cmd    (cmd),
        .stat   (stat),
        .number (s_tdata[itr_pkg::NUM_W-1:0]),
        .symbol (m_tdata),
        .last   (m_tlast),
        .error  (error)
    );

    assign m_tuser[0] = error;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a conversion is running");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == itr_pkg::CH_NONE))
        else $error("error result not a single zero symbol");

    a_letter_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
        (m_tdata == itr_pkg::CH_I || m_tdata == itr_pkg::CH_V ||
         m_tdata == itr_pkg::CH_X || m_tdata == itr_pkg::CH_L ||
         m_tdata == itr_pkg::CH_C || m_tdata == itr_pkg::CH_D ||
         m_tdata == itr_pkg::CH_M))
        else $error("symbol is not a numeral letter");

    a_no_gap_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("bubble inside a numeral run");
`endif

endmodule

// ===== tb/roman_checker.sv =====
// roman_checker: watches both stream channels of the numeral unit, predicts the
// letters of every accepted number and compares each output letter in order.
// Depends on itr_pkg for widths and letter codes.
`timescale 1ns / 1ps

module roman_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] number, [15:12] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] symbol
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,   // [0] error
    output int          mismatches,
    output int          pending,
    output int          letters_seen
);

    typedef struct packed {
        logic [itr_pkg::SYM_W-1:0] symbol;
        logic                      last;
        logic                      error;
    } letter_t;

    int unsigned numeral_weight [itr_pkg::STEPS] = '{1000, 900, 500, 400, 100, 90, 50,
                                                     40, 10, 9, 5, 4, 1};
    logic [itr_pkg::SYM_W-1:0] numeral_lead [itr_pkg::STEPS] = '{
        itr_pkg::CH_M, itr_pkg::CH_C, itr_pkg::CH_D, itr_pkg::CH_C, itr_pkg::CH_C,
        itr_pkg::CH_X, itr_pkg::CH_L, itr_pkg::CH_X, itr_pkg::CH_X, itr_pkg::CH_I,
        itr_pkg::CH_V, itr_pkg::CH_I, itr_pkg::CH_I};
    logic [itr_pkg::SYM_W-1:0] numeral_tail [itr_pkg::STEPS] = '{
        itr_pkg::CH_NONE, itr_pkg::CH_M, itr_pkg::CH_NONE, itr_pkg::CH_D,
        itr_pkg::CH_NONE, itr_pkg::CH_C, itr_pkg::CH_NONE, itr_pkg::CH_L,
        itr_pkg::CH_NONE, itr_pkg::CH_X, itr_pkg::CH_NONE, itr_pkg::CH_V,
        itr_pkg::CH_NONE};

    letter_t expected_letters [$];

    // greedy subtraction; out-of-range numbers give one error letter
    task automatic spell_numeral(input logic [itr_pkg::NUM_W-1:0] value);
        logic [itr_pkg::SYM_W-1:0] spelled [16];
        int unsigned               rest;
        int                        count;
        letter_t                   entry;
        rest  = value;
        count = 0;
        if (rest == 0 || rest > itr_pkg::MAX_VALUE)
        begin
            entry.symbol = itr_pkg::CH_NONE;
            entry.last   = 1'b1;
            entry.error  = 1'b1;
            expected_letters.push_back(entry);
        end
        else
        begin
            for (int step = 0; step < itr_pkg::STEPS; step++)
            begin
                while (rest >= numeral_weight[step])
                begin
                    rest -= numeral_weight[step];
                    spelled[count] = numeral_lead[step];
                    count++;
                    if (numeral_tail[step] != itr_pkg::CH_NONE)
                    begin
                        spelled[count] = numeral_tail[step];
                        count++;
                    end
                end
            end
            for (int k = 0; k < count; k++)
            begin
                entry.symbol = spelled[k];
                entry.last   = (k == count - 1);
                entry.error  = 1'b0;
                expected_letters.push_back(entry);
            end
        end
    endtask

    always @(posedge clk)
    begin
        letter_t want;
        if (!rst_n)
        begin
            mismatches   <= 0;
            pending      <= 0;
            letters_seen <= 0;
            expected_letters.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                letters_seen <= letters_seen + 1;
                if (expected_letters.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected letter: symbol %h last %b error %b",
                                 $realtime, m_tdata, m_tlast, m_tuser[0]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_letters.pop_front();
                    if (m_tdata !== want.symbol || m_tlast !== want.last ||
                        m_tuser[0] !== want.error)
                    begin
                        if (mismatches < 10)
                            $display({"[%0t] letter mismatch: expected symbol %h last %b ",
                                      "error %b, got symbol %h last %b error %b"},
                                     $realtime, want.symbol, want.last, want.error,
                                     m_tdata, m_tlast, m_tuser[0]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                spell_numeral(s_tdata[itr_pkg::NUM_W-1:0]);
            pending <= expected_letters.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives numbers into integer_to_roman_numeral_unit with random gaps
// and output stalls, and reports the verdict from roman_checker's counts.
// Depends on itr_pkg, roman_checker and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 197;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    int mismatches;
    int pending;
    int letters_seen;
    int sent_count;
    int error_requests;
    int cycle_count;
    bit hold_done;

    int directed_numbers [23] = '{0, 1, 4, 9, 3999, 4000, 4095, 3888, 40, 90, 400, 900,
                                  5, 50, 500, 1000, 2048, 14, 444, 1994, 3, 2730, 1365};

    integer_to_roman_numeral_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    roman_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .pending      (pending),
        .letters_seen (letters_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit quiet_phase();
        return sent_count >= 120 && sent_count < 170;
    endfunction

    task automatic send_number(input logic [itr_pkg::NUM_W-1:0] value);
        if (!quiet_phase() && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        if (value == 0 || value > itr_pkg::MAX_VALUE)
            error_requests++;
    endtask

    function automatic logic [itr_pkg::NUM_W-1:0] random_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return itr_pkg::NUM_W'($urandom_range(itr_pkg::MAX_VALUE, 1));
        else if (pick < 80)
            return ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(4095, 4000));
        else if (pick < 90)
            return itr_pkg::NUM_W'($urandom_range(50, 1));
        else
            return itr_pkg::NUM_W'($urandom_range(itr_pkg::MAX_VALUE, 3000));
    endfunction

    // output side: random stalls, one long hold-off while the sender keeps offering
    initial
    begin
        int hold_left;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && sent_count >= 60)
            begin
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end
            else if (quiet_phase())
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 7);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d letters still expected", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sent_count     = 0;
        error_requests = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 16'h0000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i])
            send_number(directed_numbers[i][itr_pkg::NUM_W-1:0]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_number(random_number());
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Converted %0d numbers (%0d out of range), checked %0d letters,",
                 sent_count, error_requests, letters_seen);
        $display("with random gaps on both sides and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
